[sv/gsc_pkg.sv]
`default_nettype none
package gsc_pkg;

  localparam int unsigned BTN_W   = 16;
  localparam int unsigned TRIG_W  = 8;
  localparam int unsigned AXIS_W  = 16;
  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned DZ_W    = 15;
  localparam int unsigned SQ_W    = 32;          // x*x + y*y tops out at 2^31
  localparam int unsigned DZSQ_W  = 2 * DZ_W;
  localparam int unsigned QUO_W   = 15;          // stick magnitude stays below 1.0
  localparam int unsigned REM_W   = SQ_W + QUO_W;
  localparam int unsigned STEP_W  = 4;
  localparam int unsigned CFG_AW  = 3;
  localparam int unsigned CFG_DW  = 32;

  localparam logic [DZ_W-1:0]   LEFT_DZ_RST     = 15'd7849;
  localparam logic [DZ_W-1:0]   RIGHT_DZ_RST    = 15'd8689;
  localparam logic [AXIS_W-1:0] FULL_SCALE      = 16'hFFFF;
  localparam logic [STEP_W-1:0] ROOT_FIRST_STEP = 4'd15;
  localparam logic [STEP_W-1:0] DIV_FIRST_STEP  = 4'd14;

  // register index, taken from paddr[2]
  localparam logic REG_LEFT_DZ  = 1'b0;
  localparam logic REG_RIGHT_DZ = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SQX,
    OP_SQY,
    OP_DZSQ,
    OP_ROOT,
    OP_NUMX,
    OP_DEN,
    OP_NUMY,
    OP_DIV
  } gsc_op_t;

  typedef struct packed {
    logic              load;
    gsc_op_t           op;
    logic [STEP_W-1:0] step;
    logic              out_load;
  } gsc_cmd_t;

  typedef struct packed {
    logic                     read_ok;
    logic [BTN_W-1:0]         buttons_now;
    logic [TRIG_W-1:0]        left_trigger_raw;
    logic [TRIG_W-1:0]        right_trigger_raw;
    logic signed [AXIS_W-1:0] left_x_raw;
    logic signed [AXIS_W-1:0] left_y_raw;
    logic signed [AXIS_W-1:0] right_x_raw;
    logic signed [AXIS_W-1:0] right_y_raw;
  } gsc_in_t;

  typedef struct packed {
    logic [BTN_W-1:0]         buttons_held;
    logic [BTN_W-1:0]         buttons_pressed;
    logic [BTN_W-1:0]         buttons_released;
    logic [LEVEL_W-1:0]       left_trigger_level;
    logic [LEVEL_W-1:0]       right_trigger_level;
    logic signed [AXIS_W-1:0] left_x_out;
    logic signed [AXIS_W-1:0] left_y_out;
    logic signed [AXIS_W-1:0] right_x_out;
    logic signed [AXIS_W-1:0] right_y_out;
  } gsc_out_t;

endpackage
`default_nettype wire

[sv/gsc_in_if.sv]
`default_nettype none
interface gsc_in_if;
  logic               valid;
  logic               ready;
  logic               read_ok;
  logic [15:0]        buttons_now;
  logic [7:0]         left_trigger_raw;
  logic [7:0]         right_trigger_raw;
  logic signed [15:0] left_x_raw;
  logic signed [15:0] left_y_raw;
  logic signed [15:0] right_x_raw;
  logic signed [15:0] right_y_raw;

  modport source (
    output valid, read_ok, buttons_now, left_trigger_raw, right_trigger_raw,
    output left_x_raw, left_y_raw, right_x_raw, right_y_raw,
    input  ready
  );
  modport sink (
    input  valid, read_ok, buttons_now, left_trigger_raw, right_trigger_raw,
    input  left_x_raw, left_y_raw, right_x_raw, right_y_raw,
    output ready
  );
endinterface
`default_nettype wire

[sv/gsc_out_if.sv]
`default_nettype none
interface gsc_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        buttons_held;
  logic [15:0]        buttons_pressed;
  logic [15:0]        buttons_released;
  logic [15:0]        left_trigger_level;
  logic [15:0]        right_trigger_level;
  logic signed [15:0] left_x_out;
  logic signed [15:0] left_y_out;
  logic signed [15:0] right_x_out;
  logic signed [15:0] right_y_out;

  modport source (
    output valid, buttons_held, buttons_pressed, buttons_released,
    output left_trigger_level, right_trigger_level,
    output left_x_out, left_y_out, right_x_out, right_y_out,
    input  ready
  );
  modport sink (
    input  valid, buttons_held, buttons_pressed, buttons_released,
    input  left_trigger_level, right_trigger_level,
    input  left_x_out, left_y_out, right_x_out, right_y_out,
    output ready
  );
endinterface
`default_nettype wire

[sv/gsc_stick.sv]
`default_nettype none
module gsc_stick
  import gsc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire gsc_cmd_t                 cmd,
  input  wire logic signed [AXIS_W-1:0] x_in,
  input  wire logic signed [AXIS_W-1:0] y_in,
  input  wire logic [DZ_W-1:0]          dz,
  output logic signed [AXIS_W-1:0]      x_out,
  output logic signed [AXIS_W-1:0]      y_out
);

  logic [AXIS_W-1:0] mx_r, my_r;
  logic              sx_r, sy_r;
  logic [SQ_W-1:0]   sq_r;
  logic [DZSQ_W-1:0] dzsq_r;
  logic [SQ_W-1:0]   rem_r, res_r;
  logic              zflag_r;
  logic [SQ_W-1:0]   den_r;
  logic [REM_W-1:0]  numx_r, numy_r;
  logic [QUO_W-1:0]  qx_r, qy_r;

  logic [AXIS_W-1:0] len_w, len_less_w, mul_a, mul_b;
  logic [SQ_W-1:0]   product, bit_w, trial_w;
  logic              root_take;
  logic [REM_W-1:0]  dsh_w;
  logic              takex, takey;
  logic [AXIS_W-1:0] qxw, qyw;

  assign len_w      = res_r[AXIS_W-1:0];
  assign len_less_w = len_w - {1'b0, dz};

  // single shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_SQX: begin
        mul_a = mx_r;
        mul_b = mx_r;
      end
      OP_SQY: begin
        mul_a = my_r;
        mul_b = my_r;
      end
      OP_DZSQ: begin
        mul_a = {1'b0, dz};
        mul_b = {1'b0, dz};
      end
      OP_NUMX: begin
        mul_a = mx_r;
        mul_b = len_less_w;
      end
      OP_DEN: begin
        mul_a = len_w;
        mul_b = FULL_SCALE - {1'b0, dz};
      end
      OP_NUMY: begin
        mul_a = my_r;
        mul_b = len_less_w;
      end
      default: ;
    endcase
  end

  assign product = mul_a * mul_b;

  // one root bit per step
  assign bit_w     = SQ_W'(1) << {cmd.step, 1'b0};
  assign trial_w   = res_r + bit_w;
  assign root_take = rem_r >= trial_w;

  // one quotient bit per step, both axes together
  assign dsh_w = REM_W'(den_r) << cmd.step;
  assign takex = numx_r >= dsh_w;
  assign takey = numy_r >= dsh_w;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx_r <= x_in[AXIS_W-1];
      sy_r <= y_in[AXIS_W-1];
      mx_r <= x_in[AXIS_W-1] ? (~$unsigned(x_in) + 16'd1) : $unsigned(x_in);
      my_r <= y_in[AXIS_W-1] ? (~$unsigned(y_in) + 16'd1) : $unsigned(y_in);
    end
    case (cmd.op)
      OP_SQX: sq_r <= product;
      OP_SQY: sq_r <= sq_r + product;
      OP_DZSQ: begin
        dzsq_r <= product[DZSQ_W-1:0];
        rem_r  <= sq_r;
        res_r  <= '0;
      end
      OP_ROOT: begin
        if (root_take) begin
          rem_r <= rem_r - trial_w;
          res_r <= (res_r >> 1) + bit_w;
        end else begin
          res_r <= res_r >> 1;
        end
      end
      OP_NUMX: begin
        numx_r  <= {product, {QUO_W{1'b0}}};
        zflag_r <= (sq_r == '0) || (sq_r < SQ_W'(dzsq_r));
      end
      OP_DEN:  den_r  <= product;
      OP_NUMY: numy_r <= {product, {QUO_W{1'b0}}};
      OP_DIV: begin
        if (takex) numx_r <= numx_r - dsh_w;
        if (takey) numy_r <= numy_r - dsh_w;
        qx_r <= {qx_r[QUO_W-2:0], takex};
        qy_r <= {qy_r[QUO_W-2:0], takey};
      end
      default: ;
    endcase
  end

  assign qxw   = {1'b0, qx_r};
  assign qyw   = {1'b0, qy_r};
  assign x_out = zflag_r ? '0 : $signed(sx_r ? (~qxw + 16'd1) : qxw);
  assign y_out = zflag_r ? '0 : $signed(sy_r ? (~qyw + 16'd1) : qyw);

  // quotient must fit in QUO_W bits outside the dead zone
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_DIV && cmd.step == DIV_FIRST_STEP && !zflag_r)
      |-> (numx_r < (REM_W'(den_r) << QUO_W)) && (numy_r < (REM_W'(den_r) << QUO_W)))
    else $error("stick quotient overflow");

endmodule
`default_nettype wire

[sv/gsc_datapath.sv]
`default_nettype none
module gsc_datapath
  import gsc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire gsc_cmd_t         cmd,
  input  wire gsc_in_t          in_data,
  input  wire logic [DZ_W-1:0]  left_dz,
  input  wire logic [DZ_W-1:0]  right_dz,
  output gsc_out_t              out_data
);

  logic [BTN_W-1:0]  prev_r, held_r, pressed_r, released_r;
  logic [TRIG_W-1:0] lt_r, rt_r;
  gsc_out_t          out_r;

  logic [BTN_W-1:0]         cur_w;
  logic signed [AXIS_W-1:0] lx_w, ly_w, rx_w, ry_w;
  logic signed [AXIS_W-1:0] lx_o, ly_o, rx_o, ry_o;
  gsc_out_t                 res_w;

  // failed read: whole sample counts as zero
  assign cur_w = in_data.read_ok ? in_data.buttons_now : '0;
  assign lx_w  = in_data.read_ok ? in_data.left_x_raw  : '0;
  assign ly_w  = in_data.read_ok ? in_data.left_y_raw  : '0;
  assign rx_w  = in_data.read_ok ? in_data.right_x_raw : '0;
  assign ry_w  = in_data.read_ok ? in_data.right_y_raw : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (cmd.load) begin
      prev_r <= cur_w;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      held_r     <= cur_w;
      pressed_r  <= ~prev_r & cur_w;
      released_r <= prev_r & ~cur_w;
      lt_r       <= in_data.read_ok ? in_data.left_trigger_raw  : '0;
      rt_r       <= in_data.read_ok ? in_data.right_trigger_raw : '0;
    end
    if (cmd.out_load) begin
      out_r <= res_w;
    end
  end

  gsc_stick u_left (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .x_in  (lx_w),
    .y_in  (ly_w),
    .dz    (left_dz),
    .x_out (lx_o),
    .y_out (ly_o)
  );

  gsc_stick u_right (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .x_in  (rx_w),
    .y_in  (ry_w),
    .dz    (right_dz),
    .x_out (rx_o),
    .y_out (ry_o)
  );

  // raw * 257 is the byte repeated
  always_comb begin
    res_w.buttons_held        = held_r;
    res_w.buttons_pressed     = pressed_r;
    res_w.buttons_released    = released_r;
    res_w.left_trigger_level  = {lt_r, lt_r};
    res_w.right_trigger_level = {rt_r, rt_r};
    res_w.left_x_out          = lx_o;
    res_w.left_y_out          = ly_o;
    res_w.right_x_out         = rx_o;
    res_w.right_y_out         = ry_o;
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

[sv/gsc_ctrl.sv]
`default_nettype none
module gsc_ctrl
  import gsc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output gsc_cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_SQX  = 10'b00_0000_0010,
    S_SQY  = 10'b00_0000_0100,
    S_DZSQ = 10'b00_0000_1000,
    S_ROOT = 10'b00_0001_0000,
    S_NUMX = 10'b00_0010_0000,
    S_DEN  = 10'b00_0100_0000,
    S_NUMY = 10'b00_1000_0000,
    S_DIV  = 10'b01_0000_0000,
    S_DONE = 10'b10_0000_0000
  } gsc_state_t;

  gsc_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              in_fire;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd.load     = 1'b0;
    cmd.op       = OP_NONE;
    cmd.step     = cnt_r;
    cmd.out_load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SQX;
        end
      end
      S_SQX: begin
        cmd.op    = OP_SQX;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        cmd.op    = OP_SQY;
        state_nxt = S_DZSQ;
      end
      S_DZSQ: begin
        cmd.op    = OP_DZSQ;
        cnt_nxt   = ROOT_FIRST_STEP;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        cmd.op = OP_ROOT;
        if (cnt_r == '0) begin
          state_nxt = S_NUMX;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_NUMX: begin
        cmd.op    = OP_NUMX;
        state_nxt = S_DEN;
      end
      S_DEN: begin
        cmd.op    = OP_DEN;
        state_nxt = S_NUMY;
      end
      S_NUMY: begin
        cmd.op    = OP_NUMY;
        cnt_nxt   = DIV_FIRST_STEP;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before taken");

  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result shown without finished item");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROOT && cnt_r != '0) |=> (state_r == S_ROOT))
    else $error("square root left early");

  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("second item taken while busy");

endmodule
`default_nettype wire

[sv/gamepad_sample_conditioner.sv]
// channel   dir  handshake        payload
// in_ch     in   valid/ready      read_ok, buttons, triggers, four stick axes
// out_ch    out  valid/ready      held/pressed/released, trigger levels, stick outs
// APB       in   psel/penable     two dead zone radii at 0x0 and 0x4, pready tied high
//
// One item at a time: accept, three multiplies for the squares, 16 steps of
// the bit-serial square root, three multiplies for numerators and denominator,
// 15 steps of restoring division (x and y side by side), then the load into
// the result register. Each stick has its own lane with one 16x16 multiplier.
// The result register frees the core, so the next item goes in while the last
// result waits; if it is still not taken when the next finishes, the core holds.
// Reset (synchronous, active low) restores the radii, clears the previous
// button mask and sends the control back to idle with out_valid low.
`default_nettype none
module gamepad_sample_conditioner
  import gsc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  gsc_in_if.sink                 in_ch,
  gsc_out_if.source              out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0]      prdata,
  output logic                   pready
);

  logic [DZ_W-1:0] left_dz_r, right_dz_r;
  logic            cfg_wr;
  gsc_cmd_t        cmd;
  gsc_in_t         in_data;
  gsc_out_t        out_data;
  logic            in_ready, out_valid;

  // ---- configuration: zero-wait APB, index from paddr[2] ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_dz_r  <= LEFT_DZ_RST;
      right_dz_r <= RIGHT_DZ_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_LEFT_DZ:  left_dz_r  <= pwdata[DZ_W-1:0];
        REG_RIGHT_DZ: right_dz_r <= pwdata[DZ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LEFT_DZ:  prdata = CFG_DW'(left_dz_r);
      REG_RIGHT_DZ: prdata = CFG_DW'(right_dz_r);
      default:      prdata = '0;
    endcase
  end

  // ---- input item ----
  always_comb begin
    in_data.read_ok           = in_ch.read_ok;
    in_data.buttons_now       = in_ch.buttons_now;
    in_data.left_trigger_raw  = in_ch.left_trigger_raw;
    in_data.right_trigger_raw = in_ch.right_trigger_raw;
    in_data.left_x_raw        = in_ch.left_x_raw;
    in_data.left_y_raw        = in_ch.left_y_raw;
    in_data.right_x_raw       = in_ch.right_x_raw;
    in_data.right_y_raw       = in_ch.right_y_raw;
  end
  assign in_ch.ready = in_ready;

  gsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  gsc_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .left_dz  (left_dz_r),
    .right_dz (right_dz_r),
    .out_data (out_data)
  );

  // ---- result item ----
  assign out_ch.valid               = out_valid;
  assign out_ch.buttons_held        = out_data.buttons_held;
  assign out_ch.buttons_pressed     = out_data.buttons_pressed;
  assign out_ch.buttons_released    = out_data.buttons_released;
  assign out_ch.left_trigger_level  = out_data.left_trigger_level;
  assign out_ch.right_trigger_level = out_data.right_trigger_level;
  assign out_ch.left_x_out          = out_data.left_x_out;
  assign out_ch.left_y_out          = out_data.left_y_out;
  assign out_ch.right_x_out         = out_data.right_x_out;
  assign out_ch.right_y_out         = out_data.right_y_out;

endmodule
`default_nettype wire

[tb/sv/tb_gamepad_sample_conditioner.sv]
`timescale 1ns / 100ps
module tb_gamepad_sample_conditioner;
  import gsc_pkg::*;

  localparam int OUT_BITS = $bits(gsc_out_t);
  localparam int REPORT_MAX = 10;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  gsc_in_if  in_ch ();
  gsc_out_if out_ch ();

  gamepad_sample_conditioner dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // One row of the directed table: either a dead zone update or a sample.
  // Rows with typed set carry a hand-worked result; the rest go to the predictor.
  typedef struct {
    bit          set_dz;
    logic [31:0] left_word;
    logic [31:0] right_word;
    gsc_in_t     smp;
    bit          typed;
    gsc_out_t    want;
  } plan_row_t;

  // predictor state: mirrors of the two radii and the previous button mask
  logic [DZ_W-1:0]  model_left_dz;
  logic [DZ_W-1:0]  model_right_dz;
  logic [BTN_W-1:0] last_buttons;

  gsc_out_t  pending_outputs [$];
  plan_row_t test_plan [$];
  int        fail_count;
  int        sender_idle_pct;
  int        taker_stall_pct;

  string field_name [9] = '{"buttons_held", "buttons_pressed", "buttons_released",
                            "left_trigger_level", "right_trigger_level",
                            "left_x_out", "left_y_out", "right_x_out", "right_y_out"};

  logic signed [AXIS_W-1:0] corner_values [6] = '{16'h8000, 16'h8001, 16'hFFFF,
                                                 16'h0000, 16'h0001, 16'h7FFF};

  // ---------------------------------------------------------------------------
  // Clock, and a hard stop well beyond the slowest legal run
  // (~820 items, plus gaps, stalls and the long hold-off).
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("gamepad_sample_conditioner verification failed");
    $finish;
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX)
      $display("[%0t] %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // floor of the square root, two bits of the radicand per step
  function automatic logic [31:0] floor_root(input logic [31:0] v);
    logic [31:0] rem;
    logic [31:0] root;
    logic [31:0] probe;
    rem   = v;
    root  = '0;
    probe = 32'h4000_0000;
    while (probe > rem)
      probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // |c| * (len - dz) / (len * (65535 - dz)) in Q1.15, truncated toward zero
  function automatic logic [AXIS_W-1:0] shrink_axis(input logic signed [AXIS_W-1:0] c,
                                                    input logic [31:0] len,
                                                    input logic [DZ_W-1:0] dz);
    longint unsigned mag;
    longint unsigned num;
    longint unsigned den;
    longint unsigned quo;
    mag = (c < 0) ? longint'(-int'(c)) : longint'(c);
    num = mag * (64'(len) - 64'(dz)) * 64'd32768;
    den = 64'(len) * (64'(FULL_SCALE) - 64'(dz));
    quo = num / den;
    if (c < 0)
      quo = -quo;
    return quo[AXIS_W-1:0];
  endfunction

  function automatic void apply_deadzone(input logic signed [AXIS_W-1:0] x,
                                         input logic signed [AXIS_W-1:0] y,
                                         input logic [DZ_W-1:0] dz,
                                         output logic signed [AXIS_W-1:0] ox,
                                         output logic signed [AXIS_W-1:0] oy);
    logic [31:0] sq;
    logic [31:0] dz_sq;
    logic [31:0] len;
    sq    = 32'(int'(x) * int'(x)) + 32'(int'(y) * int'(y));
    dz_sq = 32'(dz) * 32'(dz);
    ox    = '0;
    oy    = '0;
    // centred stick, or still inside the dead zone circle
    if (sq == 0 || sq < dz_sq)
      return;
    len = floor_root(sq);
    ox  = shrink_axis(x, len, dz);
    oy  = shrink_axis(y, len, dz);
  endfunction

  // one accepted sample in, its result out; advances the button history
  function automatic gsc_out_t predict_conditioned(input gsc_in_t smp);
    gsc_out_t r;
    gsc_in_t  v;
    // a failed read counts as an all-zero sample
    v = smp.read_ok ? smp : '0;
    r.buttons_held        = v.buttons_now;
    r.buttons_pressed     = ~last_buttons & v.buttons_now;
    r.buttons_released    = last_buttons & ~v.buttons_now;
    r.left_trigger_level  = 16'(v.left_trigger_raw) * 16'd257;
    r.right_trigger_level = 16'(v.right_trigger_raw) * 16'd257;
    apply_deadzone(v.left_x_raw, v.left_y_raw, model_left_dz, r.left_x_out, r.left_y_out);
    apply_deadzone(v.right_x_raw, v.right_y_raw, model_right_dz, r.right_x_out,
                   r.right_y_out);
    last_buttons = v.buttons_now;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic gsc_in_t sample_of(input logic ok, input logic [15:0] btn,
                                        input logic [7:0] lt, input logic [7:0] rt,
                                        input logic signed [15:0] lx,
                                        input logic signed [15:0] ly,
                                        input logic signed [15:0] rx,
                                        input logic signed [15:0] ry);
    gsc_in_t s;
    s.read_ok           = ok;
    s.buttons_now       = btn;
    s.left_trigger_raw  = lt;
    s.right_trigger_raw = rt;
    s.left_x_raw        = lx;
    s.left_y_raw        = ly;
    s.right_x_raw       = rx;
    s.right_y_raw       = ry;
    return s;
  endfunction

  function automatic void plan_sample(input gsc_in_t smp, input bit typed = 1'b0,
                                      input gsc_out_t want = '0);
    plan_row_t row;
    row.set_dz     = 1'b0;
    row.left_word  = '0;
    row.right_word = '0;
    row.smp        = smp;
    row.typed      = typed;
    row.want       = want;
    test_plan.push_back(row);
  endfunction

  function automatic void plan_deadzones(input logic [31:0] left_word,
                                         input logic [31:0] right_word);
    plan_row_t row;
    row.set_dz     = 1'b1;
    row.left_word  = left_word;
    row.right_word = right_word;
    row.smp        = '0;
    row.typed      = 1'b0;
    row.want       = '0;
    test_plan.push_back(row);
  endfunction

  // Stick pair aimed at the interesting regions: the dead zone rim most of
  // all, then full range, corners, near centre and well inside the zone.
  function automatic void pick_stick(input logic [DZ_W-1:0] dz,
                                     output logic signed [AXIS_W-1:0] x,
                                     output logic signed [AXIS_W-1:0] y);
    int r;
    int xi;
    int yi;
    case ($urandom_range(0, 5))
      0: begin
        x = AXIS_W'($urandom());
        y = AXIS_W'($urandom());
      end
      1, 2: begin
        // a point on (or a hair off) the rim of radius dz
        r = int'(dz) + int'($urandom_range(0, 6)) - 3;
        if (r < 0)
          r = 0;
        if (r > 32767)
          r = 32767;
        xi = int'($urandom_range(0, 2 * r)) - r;
        yi = int'(floor_root(32'(r * r - xi * xi)));
        if ($urandom_range(0, 1))
          yi = -yi;
        if ($urandom_range(0, 1)) begin
          x = AXIS_W'(xi);
          y = AXIS_W'(yi);
        end else begin
          x = AXIS_W'(yi);
          y = AXIS_W'(xi);
        end
      end
      3: begin
        x = corner_values[$urandom_range(0, 5)];
        y = corner_values[$urandom_range(0, 5)];
      end
      4: begin
        x = AXIS_W'(int'($urandom_range(0, 64)) - 32);
        y = AXIS_W'(int'($urandom_range(0, 64)) - 32);
      end
      default: begin
        x = AXIS_W'(int'($urandom_range(0, dz)) - int'(dz / 2));
        y = AXIS_W'(int'($urandom_range(0, dz)) - int'(dz / 2));
      end
    endcase
  endfunction

  function automatic gsc_in_t random_sample();
    gsc_in_t s;
    s.read_ok = ($urandom_range(0, 9) != 0);
    // mostly a few buttons changing against the last mask, sometimes a fresh word
    if ($urandom_range(0, 3) == 0)
      s.buttons_now = BTN_W'($urandom());
    else
      s.buttons_now = last_buttons ^ 16'($urandom() & $urandom() & $urandom());
    s.left_trigger_raw  = TRIG_W'($urandom());
    s.right_trigger_raw = TRIG_W'($urandom());
    pick_stick(model_left_dz, s.left_x_raw, s.left_y_raw);
    pick_stick(model_right_dz, s.right_x_raw, s.right_y_raw);
    return s;
  endfunction

  // Offer one item, with a random idle gap first; valid stays up when the
  // next item follows straight on.
  task automatic offer_sample(input gsc_in_t smp, input bit typed, input gsc_out_t want);
    gsc_out_t predicted;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.read_ok           <= smp.read_ok;
    in_ch.buttons_now       <= smp.buttons_now;
    in_ch.left_trigger_raw  <= smp.left_trigger_raw;
    in_ch.right_trigger_raw <= smp.right_trigger_raw;
    in_ch.left_x_raw        <= smp.left_x_raw;
    in_ch.left_y_raw        <= smp.left_y_raw;
    in_ch.right_x_raw       <= smp.right_x_raw;
    in_ch.right_y_raw       <= smp.right_y_raw;
    do @(posedge clk); while (!in_ch.ready);
    predicted = predict_conditioned(smp);
    pending_outputs.push_back(typed ? want : predicted);
  endtask

  // ---------------------------------------------------------------------------
  // APB side. Transfers run back to back; psel is only dropped by the caller.
  // ---------------------------------------------------------------------------
  task automatic write_deadzone(input logic idx, input logic [31:0] word);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // only the low 15 bits are kept
    if (idx == REG_LEFT_DZ)
      model_left_dz = word[DZ_W-1:0];
    else
      model_right_dz = word[DZ_W-1:0];
  endtask

  task automatic read_deadzone(input logic idx);
    logic [CFG_DW-1:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    want = (idx == REG_LEFT_DZ) ? CFG_DW'(model_left_dz) : CFG_DW'(model_right_dz);
    if (prdata !== want)
      note_failure($sformatf("dead zone register %0d read back %h, expected %h",
                             idx, prdata, want));
  endtask

  task automatic check_deadzones();
    read_deadzone(REG_LEFT_DZ);
    read_deadzone(REG_RIGHT_DZ);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Radii only change with the block drained: every result back, then a
  // short pause.
  task automatic update_deadzones(input logic [31:0] left_word,
                                  input logic [31:0] right_word);
    in_ch.valid <= 1'b0;
    while (pending_outputs.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
    write_deadzone(REG_LEFT_DZ, left_word);
    write_deadzone(REG_RIGHT_DZ, right_word);
    check_deadzones();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, plus one long hold-off once 200 results are taken,
  // while the sender keeps offering so the block backs up into its input.
  // ---------------------------------------------------------------------------
  initial begin : result_taker
    int taken;
    int hold_left;
    taken     = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        taken++;
        if (taken == 200)
          hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= taker_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    gsc_out_t got;
    gsc_out_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.buttons_held        = out_ch.buttons_held;
      got.buttons_pressed     = out_ch.buttons_pressed;
      got.buttons_released    = out_ch.buttons_released;
      got.left_trigger_level  = out_ch.left_trigger_level;
      got.right_trigger_level = out_ch.right_trigger_level;
      got.left_x_out          = out_ch.left_x_out;
      got.left_y_out          = out_ch.left_y_out;
      got.right_x_out         = out_ch.right_x_out;
      got.right_y_out         = out_ch.right_y_out;
      if (pending_outputs.size() == 0) begin
        note_failure($sformatf("result with no item outstanding: %h", got));
      end else begin
        want = pending_outputs.pop_front();
        // nine 16-bit fields, held word at the top
        for (int i = 0; i < 9; i++) begin
          if (got[OUT_BITS-1-16*i -: 16] !== want[OUT_BITS-1-16*i -: 16])
            note_failure($sformatf("%s: expected %h, got %h", field_name[i],
                                   want[OUT_BITS-1-16*i -: 16],
                                   got[OUT_BITS-1-16*i -: 16]));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    fail_count      = 0;
    sender_idle_pct = 0;
    taker_stall_pct = 0;
    model_left_dz   = LEFT_DZ_RST;
    model_right_dz  = RIGHT_DZ_RST;
    last_buttons    = '0;

    rst_n                   <= 1'b0;
    psel                    <= 1'b0;
    penable                 <= 1'b0;
    pwrite                  <= 1'b0;
    paddr                   <= '0;
    pwdata                  <= '0;
    in_ch.valid             <= 1'b0;
    in_ch.read_ok           <= 1'b0;
    in_ch.buttons_now       <= '0;
    in_ch.left_trigger_raw  <= '0;
    in_ch.right_trigger_raw <= '0;
    in_ch.left_x_raw        <= '0;
    in_ch.left_y_raw        <= '0;
    in_ch.right_x_raw       <= '0;
    in_ch.right_y_raw       <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // radii straight out of reset
    check_deadzones();

    // --- directed table, reset radii (7849 / 8689) ---
    // first item after reset: every button newly down, triggers full scale,
    // both sticks centred
    plan_sample(sample_of(1, 16'hFFFF, 8'hFF, 8'hFF, 0, 0, 0, 0), 1,
                gsc_out_t'{16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0});
    // failed read: everything zero, all buttons reported released
    plan_sample(sample_of(0, 16'hFFFF, 8'hFF, 8'hFF, 16'h7FFF, 16'h8000, 16'h7FFF,
                          16'h8000), 1,
                gsc_out_t'{16'h0000, 16'h0000, 16'hFFFF, 0, 0, 0, 0, 0, 0});
    // both sticks well inside their dead zones
    plan_sample(sample_of(1, 16'hAAAA, 8'h00, 8'h01, 100, -100, -5000, 5000), 1,
                gsc_out_t'{16'hAAAA, 16'hAAAA, 16'h0000, 16'h0000, 16'h0101, 0, 0, 0, 0});
    plan_sample(sample_of(1, 16'h5555, 8'h80, 8'h7F, 16'h8000, 16'h8000, 16'h7FFF,
                          16'h7FFF));
    plan_sample(sample_of(1, 16'h0000, 8'h01, 8'hFE, 16'h8000, 0, 0, 16'h8000));
    // exactly on the left rim, one short of the right rim
    plan_sample(sample_of(1, 16'h0001, 8'h40, 8'hC0, 7849, 0, 0, -8688));
    plan_sample(sample_of(1, 16'h8000, 8'h00, 8'h00, 0, -7850, -8689, 1));
    plan_sample(sample_of(1, 16'h8001, 8'hFF, 8'h00, 16'h7FFF, 16'h8000, 16'h8000,
                          16'h7FFF));
    plan_sample(sample_of(1, 16'h0F0F, 8'h12, 8'h34, 12345, -23456, -321, 30000));

    // --- extreme radii: left none at all, right full; upper bits must drop ---
    plan_deadzones(32'hFFFF_8000, 32'hFFFF_FFFF);
    // left centred with no dead zone, right on the rim at full radius
    plan_sample(sample_of(1, 16'h0000, 8'h00, 8'h00, 0, 0, 16'h7FFF, 0), 1,
                gsc_out_t'{16'h0000, 16'h0000, 16'h0F0F, 0, 0, 0, 0, 0, 0});
    plan_sample(sample_of(1, 16'hFFFF, 8'hFF, 8'h00, 1, 0, 16'h8000, 16'h8000));
    plan_sample(sample_of(1, 16'h1234, 8'h9A, 8'hBC, 16'h8000, 16'h8000, 16'h7FFF,
                          16'h8000));
    plan_sample(sample_of(1, 16'h0000, 8'h00, 8'h00, 1, 1, -1, -1));
    // failed read with nothing held before: all zero
    plan_sample(sample_of(0, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'hFFFF), 1, gsc_out_t'('0));

    // --- swapped extremes ---
    plan_deadzones(32'd32767, 32'd0);
    plan_sample(sample_of(1, 16'h1234, 8'h12, 8'h34, 30000, -30000, 0, 0));
    plan_sample(sample_of(1, 16'h4321, 8'hAB, 8'hCD, 16'h8000, 16'h8000, -1, 1));
    plan_sample(sample_of(1, 16'hFFFF, 8'hFF, 8'hFF, 16'h7FFF, 16'h7FFF, 16'h8000,
                          16'h7FFF));
    // read failure straight after a full mask
    plan_sample(sample_of(0, 16'h0000, 8'h00, 8'h00, 0, 0, 0, 0), 1,
                gsc_out_t'{16'h0000, 16'h0000, 16'hFFFF, 0, 0, 0, 0, 0, 0});

    foreach (test_plan[i]) begin
      if (test_plan[i].set_dz)
        update_deadzones(test_plan[i].left_word, test_plan[i].right_word);
      else
        offer_sample(test_plan[i].smp, test_plan[i].typed, test_plan[i].want);
    end

    // --- random part: eight phases, fresh radii each, idling pattern cycling
    // through none / sender gaps / receiver stalls / both ---
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       update_deadzones(32'(LEFT_DZ_RST), 32'(RIGHT_DZ_RST));
        1:       update_deadzones(32'd32767, 32'd0);
        3:       update_deadzones(32'd0, 32'd0);
        5:       update_deadzones(32'd32767, 32'd32767);
        default: update_deadzones($urandom(), $urandom());
      endcase
      case (phase % 4)
        0: begin
          sender_idle_pct = 0;
          taker_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 87;
          taker_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          taker_stall_pct = 87;
        end
        default: begin
          sender_idle_pct = 24;
          taker_stall_pct = 24;
        end
      endcase
      repeat (100) offer_sample(random_sample(), 1'b0, '0);
    end

    // drain, then give any stray result time to show up
    in_ch.valid <= 1'b0;
    while (pending_outputs.size() != 0)
      @(posedge clk);
    repeat (80) @(posedge clk);

    if (fail_count == 0)
      $display("gamepad_sample_conditioner verification clean");
    else
      $display("gamepad_sample_conditioner verification failed");
    $finish;
  end

endmodule
